// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/rcc_pkg.sv -----
// types, constants and arithmetic helpers of the crosstalk canceller
package rcc_pkg;

  localparam int DELAY_DEPTH = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int DELAY_W     = 10;
  localparam int GAIN_W      = 16;
  localparam int FRAC_BITS   = 16;
  localparam int WIDE_W      = SAMPLE_BITS + GAIN_W + 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
  } frame_t;

  typedef enum logic [0:0] {
    REG_DELAY = 1'b0,
    REG_GAIN  = 1'b1
  } reg_sel_t;

  function automatic wide_t widen(sample_t x);
    return {{(WIDE_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  // clamp to the signed sample range
  function automatic sample_t sat_wide(wide_t v);
    logic [WIDE_W-SAMPLE_BITS:0] upper;
    upper = v[WIDE_W-1:SAMPLE_BITS-1];
    if ((&upper) || !(|upper)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/rcc_delay_line.sv -----
// delay memory for both channels with write pointer, fill tracking and forwarding
module rcc_delay_line (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  rcc_pkg::frame_t                 wr_data,
  input  logic [rcc_pkg::DELAY_W-1:0]     delay,
  output rcc_pkg::frame_t                 rd_data
);
  import rcc_pkg::*;

  frame_t            mem [DELAY_DEPTH];
  frame_t            q_r;
  frame_t            fwd_r;
  logic              fwd_sel_r;
  logic              hit_r;
  logic [ADDR_W-1:0] wp_r;
  logic [ADDR_W-1:0] wp_nxt;
  logic              wrapped_r;
  logic              wrapped_nxt;
  logic [ADDR_W-1:0] d_eff;
  logic [ADDR_W:0]   diff;
  logic              borrow;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (32'(delay) > 32'(DELAY_DEPTH - 1)) begin
      d_eff = ADDR_W'(DELAY_DEPTH - 1);
    end else begin
      d_eff = ADDR_W'(delay);
    end
    diff   = {1'b0, wp_r} - {1'b0, d_eff};
    borrow = diff[ADDR_W];
    if (borrow) begin
      rd_addr = ADDR_W'(diff + (ADDR_W+1)'(DELAY_DEPTH));
    end else begin
      rd_addr = diff[ADDR_W-1:0];
    end
  end

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (wr_en) begin
      if (wp_r == ADDR_W'(DELAY_DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
      q_r       <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      fwd_sel_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      if (wr_en) begin
        fwd_sel_r <= (d_eff == '0);
        // entries below the pointer are written; all of them once it wrapped
        hit_r     <= wrapped_r || !borrow;
      end
    end
  end

  always_comb begin
    if (fwd_sel_r) begin
      rd_data = fwd_r;
    end else if (hit_r) begin
      rd_data = q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ----- rtl/rcc_fb_unit.sv -----
// feedback path: scale by negated gain, round, saturate and hold the feedback
module rcc_fb_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  rcc_pkg::frame_t             delayed,
  input  logic [rcc_pkg::GAIN_W-1:0]  gain,
  output rcc_pkg::frame_t             fb
);
  import rcc_pkg::*;

  frame_t fb_r;
  frame_t fb_nxt;

  function automatic sample_t scale(sample_t x, logic [GAIN_W-1:0] g);
    logic signed [SAMPLE_BITS+GAIN_W:0] prod;
    wide_t                              p;
    wide_t                              r;
    prod = (SAMPLE_BITS+GAIN_W+1)'(x) * (SAMPLE_BITS+GAIN_W+1)'($signed({1'b0, g}));
    p    = wide_t'(32'sd1 <<< (FRAC_BITS - 1)) - WIDE_W'(prod);
    // arithmetic shift floors, so ties go toward plus infinity
    r    = p >>> FRAC_BITS;
    return sat_wide(r);
  endfunction

  always_comb begin
    fb_nxt   = fb_r;
    if (load) begin
      fb_nxt.a = scale(delayed.a, gain);
      fb_nxt.b = scale(delayed.b, gain);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else begin
      fb_r <= fb_nxt;
    end
  end

  assign fb = fb_r;

endmodule

// ----- rtl/recursive_crosstalk_canceller_top.sv -----
// Recursive two-channel crosstalk canceller. Each item is a stereo frame;
// out_a is sample_a plus the feedback of channel B and out_b is sample_b plus
// the feedback of channel A, both saturated to 24 bits. The sums go into a
// 1024-entry delay memory and the entry read delay_samples frames back (zero
// means the sum just written) is scaled by -gain_magnitude in Q0.16, rounded
// and saturated into the next feedback. A new frame waits until the feedback
// of the last is ready: the delay memory read in the accept cycle and the
// multiply in the following cycle must produce it before the next frame is
// summed. A result sits in an output register from the cycle after its frame
// is taken; while it waits the input stalls, and a new frame can be taken in
// the same cycle the waiting result is taken. No clearing pass follows reset:
// entries not yet written since reset read as zero, so frames are accepted
// right away. Write registers only while no item is in flight.
`include "assert_macros.svh"

module recursive_crosstalk_canceller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rcc_pkg::SAMPLE_BITS-1:0] in_sample_a,
  input  logic signed [rcc_pkg::SAMPLE_BITS-1:0] in_sample_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rcc_pkg::SAMPLE_BITS-1:0] out_a,
  output logic signed [rcc_pkg::SAMPLE_BITS-1:0] out_b,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rcc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rcc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import rcc_pkg::*;

  logic               busy_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  sample_t            out_a_r;
  sample_t            out_b_r;
  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               in_fire;
  logic               cfg_wr;
  reg_sel_t           cfg_sel;
  frame_t             sums;
  frame_t             delayed;
  frame_t             fb;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      gain_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DELAY: delay_r <= cfg_pwdata[DELAY_W-1:0];
        REG_GAIN:  gain_r  <= cfg_pwdata[GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DELAY: cfg_prdata = CFG_DATA_W'(delay_r);
      REG_GAIN:  cfg_prdata = CFG_DATA_W'(gain_r);
    endcase
  end

  // input side: a frame may enter when the feedback is settled and the
  // output register is free or being emptied this cycle
  assign in_ready = !busy_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    sums.a = sat_wide(widen(in_sample_a) + widen(fb.b));
    sums.b = sat_wide(widen(in_sample_b) + widen(fb.a));
  end

  rcc_delay_line u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire),
    .wr_data (sums),
    .delay   (delay_r),
    .rd_data (delayed)
  );

  rcc_fb_unit u_fb (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (busy_r),
    .delayed (delayed),
    .gain    (gain_r),
    .fb      (fb)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= in_fire;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_a_r <= sums.a;
      out_b_r <= sums.b;
    end
  end

  assign out_valid = out_valid_r;
  assign out_a     = out_a_r;
  assign out_b     = out_b_r;

  `ASSERT_NEXT(a_accept_starts_fb, clk, rst_n, in_fire, busy_r && out_valid_r)
  `ASSERT_IMPLY(a_no_accept_in_fb, clk, rst_n, busy_r, !in_ready)
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !in_ready)

endmodule
